// ----- rtl/csr_pkg.sv -----
package csr_pkg;

    // Stream payload widths, packed fields rounded up to whole bytes
    localparam int IN_W  = 64;
    localparam int OUT_W = 16;

    // Configuration port
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 8;
    localparam logic [CFG_AW-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_AW-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_AW-1:0] REG_DRAW_GLYPH  = 2'd2;

    // Command codes
    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_RECT   = 3'd1;
    localparam logic [2:0] OP_LINE   = 3'd2;
    localparam logic [2:0] OP_CIRCLE = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    localparam logic [7:0] BLANK_CELL    = 8'd32;
    localparam logic [7:0] DEFAULT_GLYPH = 8'd42;
    localparam logic [6:0] DEFAULT_GRID  = 7'd64;

    // Plot coordinate width: centre plus or minus radius fits with margin
    localparam int CW = 14;

    typedef logic signed [11:0] coord_t;
    typedef logic signed [CW-1:0] pcoord_t;

    typedef struct packed {
        logic [2:0]  op;
        coord_t      xa;
        coord_t      ya;
        coord_t      xb;
        coord_t      yb;
        logic [10:0] radius;
        logic        reject;
    } cmd_t;

endpackage

// ----- rtl/csr_ram.sv -----
module csr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/csr_front.sv -----
module csr_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [csr_pkg::IN_W-1:0]  s_axis_tdata,
    input  logic                      hold,
    output csr_pkg::cmd_t             cmd,
    output logic                      cmd_valid,
    input  logic                      cmd_pop
);
    import csr_pkg::*;

    cmd_t       in_cmd;
    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;

    // Unpack and classify: flag bad rectangle corners up front
    always_comb
    begin
        in_cmd.op     = s_axis_tdata[2:0];
        in_cmd.xa     = $signed(s_axis_tdata[14:3]);
        in_cmd.ya     = $signed(s_axis_tdata[26:15]);
        in_cmd.xb     = $signed(s_axis_tdata[38:27]);
        in_cmd.yb     = $signed(s_axis_tdata[50:39]);
        in_cmd.radius = s_axis_tdata[61:51];
        in_cmd.reject = (s_axis_tdata[2:0] == OP_RECT) &&
                        (($signed(s_axis_tdata[26:15]) <= $signed(s_axis_tdata[50:39])) ||
                         ($signed(s_axis_tdata[14:3]) >= $signed(s_axis_tdata[38:27])));
    end

    assign s_axis_tready = (count_reg != 2'd2) && !hold;
    assign push          = s_axis_tvalid && s_axis_tready;
    assign cmd_valid     = (count_reg != 2'd0);
    assign cmd           = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (cmd_pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !cmd_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && cmd_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ----- rtl/csr_back.sv -----
module csr_back #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  csr_pkg::cmd_t    cmd,
    input  logic             cmd_valid,
    output logic             cmd_pop,
    input  csr_pkg::pcoord_t cols,
    input  csr_pkg::pcoord_t rows,
    input  logic [7:0]       glyph,
    output logic             init_busy,
    output logic             res_valid,
    input  logic             res_ready,
    output logic [7:0]       res_glyph,
    output logic             res_status
);
    import csr_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = CW + 1;
    localparam int DW    = 16;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CLR     = 3'd1;
    localparam logic [2:0] S_RECT_H  = 3'd2;
    localparam logic [2:0] S_RECT_V  = 3'd3;
    localparam logic [2:0] S_LINE    = 3'd4;
    localparam logic [2:0] S_CIRC    = 3'd5;
    localparam logic [2:0] S_RD      = 3'd6;
    localparam logic [2:0] S_RD_WAIT = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic                init_reg, init_next;
    logic [AW-1:0]       cnt_reg, cnt_next;
    cmd_t                cmd_reg, cmd_next;
    logic                ph_reg, ph_next;
    coord_t              cur_x_reg, cur_x_next;
    coord_t              cur_y_reg, cur_y_next;
    logic signed [EW-1:0] dx_reg, dx_next;
    logic signed [EW-1:0] dy_reg, dy_next;
    logic signed [EW-1:0] err_reg, err_next;
    logic                sx_reg, sx_next;
    logic                sy_reg, sy_next;
    logic signed [12:0]  off_x_reg, off_x_next;
    logic signed [12:0]  off_y_reg, off_y_next;
    logic signed [DW-1:0] d_reg, d_next;
    logic [2:0]          oct_reg, oct_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_glyph_reg, out_glyph_next;
    logic                out_status_reg, out_status_next;

    pcoord_t             plot_x, plot_y;
    logic                plot_en;
    pcoord_t             pl_x_reg, pl_y_reg;
    logic                pl_v_reg;

    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [7:0]          ram_wdata, ram_rdata;

    logic signed [12:0]  circ_a, circ_b;
    logic signed [EW:0]  e2;
    logic signed [12:0]  diff_x, diff_y;
    logic signed [12:0]  yn, xn;

    function automatic logic on_grid(input pcoord_t x, input pcoord_t y,
                                     input pcoord_t w, input pcoord_t h);
        return !x[CW-1] && !y[CW-1] && (x < w) && (y < h);
    endfunction

    function automatic logic [AW-1:0] addr_of(input pcoord_t x, input pcoord_t y);
        return AW'(AW'(y) * AW'(MAX_WIDTH)) + AW'(x);
    endfunction

    csr_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_canvas (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Point chosen by the running walker this cycle
    always_comb
    begin
        circ_a  = oct_reg[2] ? off_y_reg : off_x_reg;
        circ_b  = oct_reg[2] ? off_x_reg : off_y_reg;
        plot_en = 1'b0;
        plot_x  = CW'(cur_x_reg);
        plot_y  = CW'(cur_y_reg);
        unique case (state_reg)
            S_RECT_H:
            begin
                plot_en = 1'b1;
                plot_y  = ph_reg ? CW'(cmd_reg.yb) : CW'(cmd_reg.ya);
            end
            S_RECT_V:
            begin
                plot_en = 1'b1;
                plot_x  = ph_reg ? CW'(cmd_reg.xb) : CW'(cmd_reg.xa);
            end
            S_LINE:
            begin
                plot_en = 1'b1;
            end
            S_CIRC:
            begin
                plot_en = (oct_reg != 3'd0) || (off_x_reg >= off_y_reg);
                plot_x  = oct_reg[0] ? CW'(cmd_reg.xa) - CW'(circ_a)
                                     : CW'(cmd_reg.xa) + CW'(circ_a);
                plot_y  = oct_reg[1] ? CW'(cmd_reg.ya) - CW'(circ_b)
                                     : CW'(cmd_reg.ya) + CW'(circ_b);
            end
            default:
            begin
                plot_en = 1'b0;
            end
        endcase
    end

    // Write port: clear sweep or the registered plot point
    always_comb
    begin
        if (state_reg == S_CLR)
        begin
            ram_we    = 1'b1;
            ram_waddr = cnt_reg;
            ram_wdata = BLANK_CELL;
        end
        else
        begin
            ram_we    = pl_v_reg && on_grid(pl_x_reg, pl_y_reg, cols, rows);
            ram_waddr = addr_of(pl_x_reg, pl_y_reg);
            ram_wdata = glyph;
        end
        ram_re    = (state_reg == S_RD);
        ram_raddr = addr_of(CW'(cmd_reg.xa), CW'(cmd_reg.ya));
    end

    assign e2     = {err_reg, 1'b0};
    assign diff_x = 13'(cmd.xb) - 13'(cmd.xa);
    assign diff_y = 13'(cmd.yb) - 13'(cmd.ya);
    assign yn     = off_y_reg + 13'sd1;
    assign xn     = off_x_reg - 13'sd1;

    always_comb
    begin
        state_next      = state_reg;
        init_next       = init_reg;
        cnt_next        = cnt_reg;
        cmd_next        = cmd_reg;
        ph_next         = ph_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        err_next        = err_reg;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        off_x_next      = off_x_reg;
        off_y_next      = off_y_reg;
        d_next          = d_reg;
        oct_next        = oct_reg;
        out_valid_next  = out_valid_reg;
        out_glyph_next  = out_glyph_reg;
        out_status_next = out_status_reg;
        cmd_pop         = 1'b0;

        if (out_valid_reg && res_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && !out_valid_reg)
                begin
                    cmd_pop         = 1'b1;
                    cmd_next        = cmd;
                    ph_next         = 1'b0;
                    out_glyph_next  = BLANK_CELL;
                    out_status_next = 1'b0;
                    cur_x_next      = cmd.xa;
                    cur_y_next      = cmd.ya;
                    case (cmd.op)
                        OP_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = S_CLR;
                        end
                        OP_RECT:
                        begin
                            if (cmd.reject)
                            begin
                                out_status_next = 1'b1;
                                out_valid_next  = 1'b1;
                            end
                            else
                            begin
                                state_next = S_RECT_H;
                            end
                        end
                        OP_LINE:
                        begin
                            dx_next    = diff_x[12] ? -EW'(diff_x) : EW'(diff_x);
                            dy_next    = diff_y[12] ? EW'(diff_y) : -EW'(diff_y);
                            err_next   = (diff_x[12] ? -EW'(diff_x) : EW'(diff_x)) +
                                         (diff_y[12] ? EW'(diff_y) : -EW'(diff_y));
                            sx_next    = cmd.xa < cmd.xb;
                            sy_next    = cmd.ya < cmd.yb;
                            state_next = S_LINE;
                        end
                        OP_CIRCLE:
                        begin
                            off_x_next = $signed({2'b00, cmd.radius});
                            off_y_next = '0;
                            d_next     = DW'(1) - DW'({5'd0, cmd.radius});
                            oct_next   = 3'd0;
                            state_next = S_CIRC;
                        end
                        OP_READ:
                        begin
                            if (on_grid(CW'(cmd.xa), CW'(cmd.ya), cols, rows))
                            begin
                                state_next = S_RD;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_CLR:
            begin
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                    if (init_reg)
                    begin
                        init_next = 1'b0;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            S_RECT_H:
            begin
                ph_next = ~ph_reg;
                if (ph_reg)
                begin
                    if (cur_x_reg == cmd_reg.xb)
                    begin
                        cur_y_next = cmd_reg.yb;
                        state_next = S_RECT_V;
                    end
                    else
                    begin
                        cur_x_next = cur_x_reg + 12'sd1;
                    end
                end
            end
            S_RECT_V:
            begin
                ph_next = ~ph_reg;
                if (ph_reg)
                begin
                    if (cur_y_reg == cmd_reg.ya)
                    begin
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        cur_y_next = cur_y_reg + 12'sd1;
                    end
                end
            end
            S_LINE:
            begin
                if ((cur_x_reg == cmd_reg.xb) && (cur_y_reg == cmd_reg.yb))
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    if (e2 >= (EW+1)'(dy_reg) && e2 <= (EW+1)'(dx_reg))
                    begin
                        err_next = err_reg + dy_reg + dx_reg;
                    end
                    else if (e2 >= (EW+1)'(dy_reg))
                    begin
                        err_next = err_reg + dy_reg;
                    end
                    else if (e2 <= (EW+1)'(dx_reg))
                    begin
                        err_next = err_reg + dx_reg;
                    end
                    if (e2 >= (EW+1)'(dy_reg))
                    begin
                        cur_x_next = sx_reg ? cur_x_reg + 12'sd1 : cur_x_reg - 12'sd1;
                    end
                    if (e2 <= (EW+1)'(dx_reg))
                    begin
                        cur_y_next = sy_reg ? cur_y_reg + 12'sd1 : cur_y_reg - 12'sd1;
                    end
                end
            end
            S_CIRC:
            begin
                if ((oct_reg == 3'd0) && (off_x_reg < off_y_reg))
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    oct_next = oct_reg + 3'd1;
                    if (oct_reg == 3'd7)
                    begin
                        off_y_next = yn;
                        if (d_reg < 0)
                        begin
                            d_next = d_reg + DW'({yn, 1'b0}) + DW'(1);
                        end
                        else
                        begin
                            // y - x goes negative on most steps: keep the sign
                            off_x_next = xn;
                            d_next     = d_reg + DW'($signed({(yn - xn), 1'b0})) + DW'(1);
                        end
                    end
                end
            end
            S_RD:
            begin
                state_next = S_RD_WAIT;
            end
            S_RD_WAIT:
            begin
                out_glyph_next = ram_rdata;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            init_reg      <= 1'b1;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            pl_v_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            pl_v_reg      <= plot_en;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        ph_reg         <= ph_next;
        cur_x_reg      <= cur_x_next;
        cur_y_reg      <= cur_y_next;
        dx_reg         <= dx_next;
        dy_reg         <= dy_next;
        err_reg        <= err_next;
        sx_reg         <= sx_next;
        sy_reg         <= sy_next;
        off_x_reg      <= off_x_next;
        off_y_reg      <= off_y_next;
        d_reg          <= d_next;
        oct_reg        <= oct_next;
        out_glyph_reg  <= out_glyph_next;
        out_status_reg <= out_status_next;
        pl_x_reg       <= plot_x;
        pl_y_reg       <= plot_y;
    end

    assign init_busy  = init_reg;
    assign res_valid  = out_valid_reg;
    assign res_glyph  = out_glyph_reg;
    assign res_status = out_status_reg;

endmodule

// ----- rtl/canvas_shape_rasterizer_core.sv -----
// Character canvas rasterizer: one command per input transfer, one result per command.
//
// Input stream (s_axis_*): tdata carries op, x_first, y_first, x_second, y_second and
// radius. Ops are clear, rectangle outline, line, circle outline and read cell.
// Output stream (m_axis_*): tdata carries cell_glyph (the read cell, else 32) and
// status (1 when rectangle corners are rejected).
// Configuration: cfg_we/cfg_addr/cfg_data write grid_width, grid_height and
// draw_glyph; write only while no command is in flight.
//
// Drawing: the canvas has one write port, so drawing runs one cell per cycle.
// A line plots max(|dx|,|dy|)+1 cells, a circle eight cells per octant step,
// a rectangle 2*(width+1)+2*(height+1) cells and a clear MAX_WIDTH*MAX_HEIGHT
// cells; a read passes through a read state and then a wait state for the RAM.
// A two-entry command queue takes transfers while a command draws, until full.
//
// Reset: the canvas is swept to blanks, all MAX_WIDTH*MAX_HEIGHT cells (4096 at
// the defaults), with s_axis_tready held low; configuration writes are taken.
// Stall: a result holds in the output register until taken; the next command
// does not start until that register is free.
module canvas_shape_rasterizer_core #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // op[2:0], x_first[14:3], y_first[26:15], x_second[38:27], y_second[50:39],
    // radius[61:51], zero fill above
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [csr_pkg::IN_W-1:0]      s_axis_tdata,
    // cell_glyph[7:0], status[8], zero fill above
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [csr_pkg::OUT_W-1:0]     m_axis_tdata,
    input  logic                          cfg_we,
    input  logic [csr_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [csr_pkg::CFG_DW-1:0]    cfg_data
);
    import csr_pkg::*;

    logic [6:0] grid_w_reg;
    logic [6:0] grid_h_reg;
    logic [7:0] glyph_reg;
    pcoord_t    cols, rows;
    cmd_t       cmd;
    logic       cmd_valid, cmd_pop, init_busy;
    logic [7:0] res_glyph;
    logic       res_status;

    // Register writes; an unused index is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_w_reg <= DEFAULT_GRID;
            grid_h_reg <= DEFAULT_GRID;
            glyph_reg  <= DEFAULT_GLYPH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_GRID_WIDTH:  grid_w_reg <= cfg_data[6:0];
                REG_GRID_HEIGHT: grid_h_reg <= cfg_data[6:0];
                REG_DRAW_GLYPH:  glyph_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Saturate the grid size into 1..MAX
    always_comb
    begin
        if (grid_w_reg == 7'd0)
            cols = CW'(1);
        else if (CW'(grid_w_reg) > CW'(MAX_WIDTH))
            cols = CW'(MAX_WIDTH);
        else
            cols = CW'(grid_w_reg);
        if (grid_h_reg == 7'd0)
            rows = CW'(1);
        else if (CW'(grid_h_reg) > CW'(MAX_HEIGHT))
            rows = CW'(MAX_HEIGHT);
        else
            rows = CW'(grid_h_reg);
    end

    csr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .hold          (init_busy),
        .cmd           (cmd),
        .cmd_valid     (cmd_valid),
        .cmd_pop       (cmd_pop)
    );

    csr_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cmd_valid  (cmd_valid),
        .cmd_pop    (cmd_pop),
        .cols       (cols),
        .rows       (rows),
        .glyph      (glyph_reg),
        .init_busy  (init_busy),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res_glyph  (res_glyph),
        .res_status (res_status)
    );

    assign m_axis_tdata = {7'd0, res_status, res_glyph};

endmodule

// ----- rtl/csr_checker.sv -----
module csr_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    input  logic                       s_axis_tready,
    input  logic [csr_pkg::IN_W-1:0]   s_axis_tdata,
    input  logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    input  logic [csr_pkg::OUT_W-1:0]  m_axis_tdata,
    input  logic                       cfg_we,
    input  logic [csr_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [csr_pkg::CFG_DW-1:0] cfg_data
);
    import csr_pkg::*;

    // A held result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // A rejected rectangle never carries a cell
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tdata[7:0] == BLANK_CELL)
        else $error("rejected rectangle with a glyph");

    // Fill bits stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_W-1:9] == '0)
        else $error("result fill bits set");

    // The clearing sweep blocks input right after reset
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !s_axis_tready)
        else $error("input taken during clearing sweep");

endmodule

bind canvas_shape_rasterizer_core csr_checker u_csr_checker (.*);

// ----- tb/sv/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import csr_pkg::*;

    // Op codes the block must ignore: no drawing, blank glyph, status 0
    localparam logic [2:0] OP_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] OP_RESERVED_LAST  = 3'd7;
    // Register index past the last register; the block drops the write
    localparam logic [CFG_AW-1:0] REG_UNUSED = 2'd3;

    localparam int CANVAS_COLS   = 64;
    localparam int CANVAS_ROWS   = 64;
    localparam int ITEMS_PER_SET = 250;
    // A full-range circle and the reset sweep both run with no transfer at either side;
    // leave ample headroom for receiver stalls.
    localparam int STALL_LIMIT   = 200000;

    // Shadow of the canvas plus the register file; predicts one result per command
    class canvas_scoreboard;
        byte unsigned cells [CANVAS_COLS*CANVAS_ROWS];
        bit [6:0]     width_reg;
        bit [6:0]     height_reg;
        bit [7:0]     glyph_reg;
        bit [8:0]     awaited [$];   // {status, cell_glyph}
        int           errors;

        function new();
            foreach (cells[i]) cells[i] = BLANK_CELL;
            width_reg  = DEFAULT_GRID;
            height_reg = DEFAULT_GRID;
            glyph_reg  = DEFAULT_GLYPH;
            errors     = 0;
        endfunction

        task report(input string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        function int cols_active();
            if (width_reg == 0) return 1;
            if (width_reg > CANVAS_COLS) return CANVAS_COLS;
            return width_reg;
        endfunction

        function int rows_active();
            if (height_reg == 0) return 1;
            if (height_reg > CANVAS_ROWS) return CANVAS_ROWS;
            return height_reg;
        endfunction

        function bit on_grid(int x, int y);
            return x >= 0 && y >= 0 && x < cols_active() && y < rows_active();
        endfunction

        function void plot(int x, int y);
            if (on_grid(x, y)) cells[y*CANVAS_COLS + x] = glyph_reg;
        endfunction

        function void write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
            case (idx)
                REG_GRID_WIDTH:  width_reg  = val[6:0];
                REG_GRID_HEIGHT: height_reg = val[6:0];
                REG_DRAW_GLYPH:  glyph_reg  = val;
                default: ;
            endcase
        endfunction

        function void trace_line(int x0, int y0, int x1, int y1);
            int dx, dy, sx, sy, err, e2;
            dx  = (x1 > x0) ? x1 - x0 : x0 - x1;
            dy  = (y1 > y0) ? y0 - y1 : y1 - y0;
            sx  = (x0 < x1) ? 1 : -1;
            sy  = (y0 < y1) ? 1 : -1;
            err = dx + dy;
            forever begin
                plot(x0, y0);
                if (x0 == x1 && y0 == y1) break;
                e2 = 2 * err;
                if (e2 >= dy) begin err += dy; x0 += sx; end
                if (e2 <= dx) begin err += dx; y0 += sy; end
            end
        endfunction

        function void trace_circle(int cx, int cy, int r);
            int x, y, d;
            x = r;
            y = 0;
            d = 1 - r;
            while (x >= y) begin
                plot(cx + x, cy + y); plot(cx - x, cy + y);
                plot(cx + x, cy - y); plot(cx - x, cy - y);
                plot(cx + y, cy + x); plot(cx - y, cy + x);
                plot(cx + y, cy - x); plot(cx - y, cy - x);
                y++;
                if (d < 0) d += 2 * y + 1;
                else begin
                    x--;
                    d += 2 * (y - x) + 1;
                end
            end
        endfunction

        function void note_command(logic [IN_W-1:0] d);
            logic [2:0] op;
            int xa, ya, xb, yb, r, i;
            bit [7:0] glyph;
            bit rejected;
            op  = d[2:0];
            xa  = coord_t'(d[14:3]);
            ya  = coord_t'(d[26:15]);
            xb  = coord_t'(d[38:27]);
            yb  = coord_t'(d[50:39]);
            r   = d[61:51];
            glyph    = BLANK_CELL;
            rejected = 1'b0;
            case (op)
                OP_CLEAR: foreach (cells[k]) cells[k] = BLANK_CELL;
                OP_RECT: begin
                    if (ya <= yb || xa >= xb) rejected = 1'b1;
                    else begin
                        for (i = xa; i <= xb; i++) begin plot(i, ya); plot(i, yb); end
                        for (i = yb; i <= ya; i++) begin plot(xa, i); plot(xb, i); end
                    end
                end
                OP_LINE:   trace_line(xa, ya, xb, yb);
                OP_CIRCLE: trace_circle(xa, ya, r);
                OP_READ:   if (on_grid(xa, ya)) glyph = cells[ya*CANVAS_COLS + xa];
                default: ;
            endcase
            awaited.push_back({rejected, glyph});
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        task check_result(logic [OUT_W-1:0] d);
            bit [8:0] want;
            if (awaited.size() == 0) begin
                report($sformatf("result %h with nothing outstanding", d));
                return;
            end
            want = awaited.pop_front();
            if (d[7:0] !== want[7:0])
                report($sformatf("cell_glyph %0d, predicted %0d", d[7:0], want[7:0]));
            if (d[8] !== want[8])
                report($sformatf("status %0b, predicted %0b", d[8], want[8]));
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 cfg_we = 1'b0;
    logic [CFG_AW-1:0]    cfg_addr = '0;
    logic [CFG_DW-1:0]    cfg_data = '0;

    canvas_scoreboard     board = new();
    int                   sender_idle_pct = 0;
    int                   stall_pct = 0;
    int                   quiet_cycles = 0;

    canvas_shape_rasterizer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    // Receiver: stall at the rate of the current phase
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Observe every transfer and register write on the edge that commits it
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we) board.write_reg(cfg_addr, cfg_data);
            if (s_axis_tvalid && s_axis_tready) board.note_command(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
        end
    end

    // Watchdog: count cycles in which neither side moves a transfer
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [IN_W-1:0] pack_cmd(logic [2:0] op, int xa, int ya,
                                                 int xb, int yb, int r);
        coord_t cxa, cya, cxb, cyb;
        logic [10:0] rad;
        cxa = xa; cya = ya; cxb = xb; cyb = yb; rad = r;
        return {2'b00, rad, cyb, cxb, cya, cxa, op};
    endfunction

    // Mostly near the grid so draws land and clip; now and then anywhere
    function automatic int pick_coord();
        if ($urandom_range(99) < 6) return coord_t'($urandom_range(4095));
        return $urandom_range(75) - 6;
    endfunction

    function automatic logic [IN_W-1:0] random_cmd();
        int pick, r;
        logic [2:0] op;
        pick = $urandom_range(99);
        if (pick < 3)       op = OP_CLEAR;
        else if (pick < 22) op = OP_RECT;
        else if (pick < 44) op = OP_LINE;
        else if (pick < 60) op = OP_CIRCLE;
        else if (pick < 95) op = OP_READ;
        else                op = 3'($urandom_range(OP_RESERVED_LAST, OP_RESERVED_FIRST));
        pick = $urandom_range(99);
        if (pick < 90)      r = $urandom_range(40);
        else if (pick < 98) r = $urandom_range(300);
        else                r = $urandom_range(2047);
        // Rectangles: mostly well-ordered corners, some rejected
        if (op == OP_RECT && $urandom_range(99) < 80)
        begin
            int l, b;
            l = pick_coord();
            b = pick_coord();
            return pack_cmd(op, l, b + 1 + $urandom_range(30), l + 1 + $urandom_range(30), b, r);
        end
        return pack_cmd(op, pick_coord(), pick_coord(), pick_coord(), pick_coord(), r);
    endfunction

    // Present one command and hold it until the block takes it
    task automatic send_cmd(input logic [IN_W-1:0] d);
        bit taken;
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do
        begin
            @(negedge clk);
            taken = s_axis_tready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    // Hold the sender off until every outstanding result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // Reprogram the grid while idle; the wait after the drain covers the command tail
    task automatic set_grid(input logic [CFG_DW-1:0] w, input logic [CFG_DW-1:0] h,
                            input logic [CFG_DW-1:0] g);
        drain();
        repeat (8) @(posedge clk);
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_HEIGHT, h);
        write_reg(REG_UNUSED, 8'hA5);
        write_reg(REG_DRAW_GLYPH, g);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: corners, clipping, rejections and the degenerate shapes
        send_cmd(pack_cmd(OP_READ, 0, 0, 0, 0, 0));
        send_cmd(pack_cmd(OP_RECT, 2, 20, 30, 3, 0));
        send_cmd(pack_cmd(OP_READ, 2, 10, 0, 0, 0));
        send_cmd(pack_cmd(OP_RECT, 5, 5, 9, 5, 0));        // top equals bottom
        send_cmd(pack_cmd(OP_RECT, 9, 8, 9, 2, 0));        // left equals right
        send_cmd(pack_cmd(OP_RECT, -5, 70, 70, -5, 0));    // outline fully off grid
        send_cmd(pack_cmd(OP_LINE, 40, 40, 40, 40, 0));    // single point
        send_cmd(pack_cmd(OP_READ, 40, 40, 0, 0, 0));
        send_cmd(pack_cmd(OP_LINE, 50, 60, 50, 10, 0));    // vertical, downward
        send_cmd(pack_cmd(OP_READ, 50, 33, 0, 0, 0));
        send_cmd(pack_cmd(OP_LINE, 0, 63, 63, 50, 0));
        send_cmd(pack_cmd(OP_LINE, -2048, -2048, 2047, 2047, 0));
        send_cmd(pack_cmd(OP_READ, 63, 63, 0, 0, 0));
        send_cmd(pack_cmd(OP_CIRCLE, 20, 40, 0, 0, 0));    // zero radius
        send_cmd(pack_cmd(OP_CIRCLE, 0, 0, -1, -1, 7));    // clipped at the corner
        send_cmd(pack_cmd(OP_READ, 7, 0, 0, 0, 0));
        send_cmd(pack_cmd(OP_CIRCLE, 2047, -2048, 2047, 2047, 2047));
        send_cmd(pack_cmd(OP_READ, -1, 0, 0, 0, 0));
        send_cmd(pack_cmd(OP_READ, 64, 63, 0, 0, 0));
        send_cmd(pack_cmd(OP_RESERVED_FIRST, 1, 1, 1, 1, 1));
        send_cmd(pack_cmd(3'd6, -1, -1, -1, -1, 2047));
        send_cmd(pack_cmd(OP_RESERVED_LAST, 0, 0, 0, 0, 0));
        send_cmd(pack_cmd(OP_CLEAR, 0, 0, 0, 0, 0));
        send_cmd(pack_cmd(OP_READ, 2, 10, 0, 0, 0));

        // Random sets, each with its own grid and its own idling mix
        for (int set = 0; set < 5; set++)
        begin
            case (set)
                0: set_grid(8'd64, 8'd64, 8'd42);
                1: set_grid(8'd127, 8'd0, 8'd255);   // both saturate
                2: set_grid(8'd0, 8'd255, 8'd0);     // upper bit dropped, then saturate
                3: set_grid(8'($urandom_range(1, 64)), 8'($urandom_range(1, 64)),
                            8'($urandom_range(255)));
                default: set_grid(8'd1, 8'd64, 8'($urandom_range(255)));
            endcase
            case (set)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 55; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 55; end
                3: begin sender_idle_pct = 31; stall_pct = 31; end
                default: begin sender_idle_pct = 0; stall_pct = 0; end
            endcase
            for (int n = 0; n < ITEMS_PER_SET; n++)
            begin
                // Last set toggles idling in stretches so gaps land on every phase
                if (set == 4 && n % 50 == 0)
                begin
                    sender_idle_pct = $urandom_range(1) ? 31 : 0;
                    stall_pct       = $urandom_range(1) ? 55 : 0;
                end
                if (n == ITEMS_PER_SET / 2) drain();
                send_cmd(random_cmd());
            end
        end

        drain();
        stall_pct = 0;
        repeat (50) @(posedge clk);
        if (board.pending() != 0) board.report("results still outstanding at end");
        if (board.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/csr_pkg.sv
rtl/csr_ram.sv
rtl/csr_front.sv
rtl/csr_back.sv
rtl/canvas_shape_rasterizer_core.sv
rtl/csr_checker.sv
tb/sv/testbench.sv
